>>> hw/rtl/psp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types and constants of the procedural solid pattern block.
// ----------------------------------------------------------------------------
package psp_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int COORD_W             = 32;
    localparam int SQ_W                = 2 * COORD_W;
    localparam int COLOR_W             = 16;
    localparam int RGB_W               = 3 * COLOR_W;
    localparam int MODE_W              = 3;
    localparam int CFG_IDX_W           = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_CHECKER  = 3'd0,
        MODE_STRIPE   = 3'd1,
        MODE_RING     = 3'd2,
        MODE_GRADIENT = 3'd3,
        MODE_RADIAL   = 3'd4
    } pattern_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_MODE = 2'd0,
        REG_COLOR_A      = 2'd1,
        REG_COLOR_B      = 2'd2
    } cfg_reg_t;

endpackage : psp_pkg
`default_nettype wire

>>> hw/rtl/procedural_solid_pattern.sv
// Throughput: one point per cycle while the skid is empty; the 32-step integer
// square root is unrolled into 32 register stages, one root bit each, after abs,
// square and add stages. A one-beat skid behind the output register lets the pipe
// advance once more while a result waits; s_ready drops only while the skid is
// occupied. Reset (aresetn low, synchronous) clears all valid bits and the
// configuration registers.
`default_nettype none
// ----------------------------------------------------------------------------
// procedural_solid_pattern
// Checker, stripe, ring, linear and radial gradient colors for one Q-format
// point per cycle while the skid is empty, selected by the pattern mode register.
// ----------------------------------------------------------------------------
module procedural_solid_pattern
    import psp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [RGB_W-1:0]     cfg_wdata,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [COORD_W-1:0] s_point_x,
    input  wire logic signed [COORD_W-1:0] s_point_y,
    input  wire logic signed [COORD_W-1:0] s_point_z,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [COLOR_W-1:0]        m_red,
    output logic [COLOR_W-1:0]        m_green,
    output logic [COLOR_W-1:0]        m_blue
);

    localparam int F          = COORD_FRAC_BITS;
    localparam int ROOT_W     = COORD_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int CAND_W     = REM_W + 2;
    localparam int SIDE_W     = F + 2;          // x fraction, checker odd, stripe odd
    // stage 0 abs, 1 square, 2 sum, 3..34 root steps, 35 blend products
    localparam int ROOT_BASE  = 2;
    localparam int BLEND_STG  = ROOT_BASE + ROOT_STEPS + 1;
    localparam int NSTAGE     = BLEND_STG + 1;
    localparam int PROD_W     = COLOR_W + F + 1;
    localparam int SUM_W      = PROD_W + 1;

    // ---------------- configuration ----------------
    logic [MODE_W-1:0] mode_reg;
    logic [RGB_W-1:0]  color_a_reg;
    logic [RGB_W-1:0]  color_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= '0;
            color_a_reg <= '0;
            color_b_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_MODE: mode_reg    <= cfg_wdata[MODE_W-1:0];
                REG_COLOR_A:      color_a_reg <= cfg_wdata;
                REG_COLOR_B:      color_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic              en;
    logic [NSTAGE-1:0] vld_reg;
    logic              skid_vld_reg;

    assign en      = !skid_vld_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_valid};
        end
    end

    logic [SIDE_W-1:0] side_reg [NSTAGE-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= {s_point_x[F-1:0], s_point_x[F] ^ s_point_y[F] ^ s_point_z[F],
                            s_point_x[F]};
            for (int i = 1; i < NSTAGE - 1; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- abs, square, sum ----------------
    logic [COORD_W-1:0] ax_reg, az_reg;
    logic [SQ_W-1:0]    sqx_reg, sqz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= s_point_x[COORD_W-1] ? COORD_W'(-s_point_x) : COORD_W'(s_point_x);
            az_reg  <= s_point_z[COORD_W-1] ? COORD_W'(-s_point_z) : COORD_W'(s_point_z);
            sqx_reg <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sqz_reg <= SQ_W'(az_reg) * SQ_W'(az_reg);
        end
    end

    // ---------------- integer square root, one bit per stage ----------------
    // index 0 holds the radicand, index k holds the state after k root bits
    logic [SQ_W-1:0]   rn_reg   [ROOT_STEPS+1];
    logic [REM_W-1:0]  rem_reg  [ROOT_STEPS+1];
    logic [ROOT_W-1:0] root_reg [ROOT_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rn_reg[0]   <= sqx_reg + sqz_reg;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= ROOT_STEPS; k++) begin : g_root
        logic [CAND_W-1:0] cand;
        logic [CAND_W-1:0] trial;
        logic              take;

        always_comb begin
            cand  = {rem_reg[k-1], rn_reg[k-1][SQ_W-1 -: 2]};
            trial = CAND_W'({root_reg[k-1], 2'b01});
            take  = cand >= trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rn_reg[k]   <= {rn_reg[k-1][SQ_W-3:0], 2'b00};
                rem_reg[k]  <= take ? REM_W'(cand - trial) : cand[REM_W-1:0];
                root_reg[k] <= {root_reg[k-1][ROOT_W-2:0], take};
            end
        end
    end

    // ---------------- color select and blend products ----------------
    logic [SIDE_W-1:0]  side_last;
    logic [ROOT_W-1:0]  radius;
    logic               blend_sel;
    logic [F-1:0]       f_sel;
    logic [RGB_W-1:0]   col_sel;
    logic [F:0]         wa;

    assign side_last = side_reg[NSTAGE-2];
    assign radius    = root_reg[ROOT_STEPS];

    always_comb begin
        blend_sel = 1'b0;
        f_sel     = side_last[SIDE_W-1 -: F];
        col_sel   = color_a_reg;
        unique case (pattern_mode_t'(mode_reg))
            MODE_CHECKER:  col_sel = side_last[1] ? color_b_reg : color_a_reg;
            MODE_STRIPE:   col_sel = side_last[0] ? color_b_reg : color_a_reg;
            MODE_RING:     col_sel = radius[F] ? color_b_reg : color_a_reg;
            MODE_GRADIENT: blend_sel = 1'b1;
            MODE_RADIAL: begin
                blend_sel = 1'b1;
                f_sel     = radius[F-1:0];
            end
            default:       col_sel = color_a_reg;
        endcase
        wa = {1'b1, {F{1'b0}}} - {1'b0, f_sel};
    end

    logic              blend_reg;
    logic [RGB_W-1:0]  col_reg;
    logic [PROD_W-1:0] pa_reg [3];
    logic [PROD_W-1:0] pb_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            blend_reg <= blend_sel;
            col_reg   <= col_sel;
            for (int c = 0; c < 3; c++) begin
                pa_reg[c] <= PROD_W'(color_a_reg[RGB_W-1-COLOR_W*c -: COLOR_W])
                           * PROD_W'(wa);
                pb_reg[c] <= PROD_W'(color_b_reg[RGB_W-1-COLOR_W*c -: COLOR_W])
                           * PROD_W'(f_sel);
            end
        end
    end

    logic [SUM_W-1:0]  sum_c [3];
    logic [RGB_W-1:0]  res_rgb;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum_c[c] = SUM_W'(pa_reg[c]) + SUM_W'(pb_reg[c]) + (SUM_W'(1) << (F - 1));
            res_rgb[RGB_W-1-COLOR_W*c -: COLOR_W] = blend_reg ? sum_c[c][F +: COLOR_W]
                                                              : col_reg[RGB_W-1-COLOR_W*c -: COLOR_W];
        end
    end

    // ---------------- output register and skid ----------------
    logic             m_valid_reg;
    logic [RGB_W-1:0] out_reg;
    logic [RGB_W-1:0] skid_reg;
    logic             out_free;
    logic             pipe_out;

    assign out_free = !m_valid_reg || m_ready;
    assign pipe_out = en && vld_reg[NSTAGE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            priority if (skid_vld_reg) begin
                if (out_free) begin
                    m_valid_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
            end else if (pipe_out) begin
                if (out_free) begin
                    m_valid_reg <= 1'b1;
                end else begin
                    skid_vld_reg <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (skid_vld_reg) begin
            if (out_free) begin
                out_reg <= skid_reg;
            end
        end else if (pipe_out) begin
            if (out_free) begin
                out_reg <= res_rgb;
            end else begin
                skid_reg <= res_rgb;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = out_reg[RGB_W-1 -: COLOR_W];
    assign m_green = out_reg[2*COLOR_W-1 -: COLOR_W];
    assign m_blue  = out_reg[COLOR_W-1:0];

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled without an output stall");

    a_skid_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg && !m_ready |=> skid_vld_reg && $stable(skid_reg))
        else $error("skid beat lost during output stall");

    a_no_accept_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |=> $stable(vld_reg))
        else $error("pipeline moved while skid was full");

endmodule : procedural_solid_pattern
`default_nettype wire
